// File: hdl/lhfg_pkg.sv
// Shared types and constants for the LED hue fade generator.
package lhfg_pkg;

	localparam int HUE_W  = 9;
	localparam int STEP_W = 7;
	localparam int PCT_W  = 7;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 2;

	localparam logic [STEP_W-1:0] STEP_LAST      = 7'd99;
	localparam logic [HUE_W-1:0]  RAMP_B_TO_INIT = 9'd60;
	localparam logic [9:0]        HUE_CIRCLE     = 10'd360;
	localparam logic [9:0]        HUE_SECTOR     = 10'd60;
	localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
	localparam logic [7:0]        LEVEL_MAX      = 8'd255;

	// floor(x/100) = (x * RECIP_100) >> RECIP_100_SH for x < 2^16
	localparam logic [16:0] RECIP_100    = 17'd83887;
	localparam int          RECIP_100_SH = 23;
	// floor(x/60) = (x * RECIP_60) >> RECIP_60_SH for x < 2^14
	localparam logic [14:0] RECIP_60     = 15'd17477;
	localparam int          RECIP_60_SH  = 20;

	localparam logic CMD_TICK       = 1'b0;
	localparam logic CMD_CLEAR      = 1'b1;
	localparam logic EFFECT_RAMP    = 1'b0;
	localparam logic EFFECT_SEGMENT = 1'b1;

	localparam logic [ADDR_W-1:0] REG_FIRST_HUE  = 2'd0;
	localparam logic [ADDR_W-1:0] REG_SECOND_HUE = 2'd1;
	localparam logic [ADDR_W-1:0] REG_BRIGHTNESS = 2'd2;
	localparam logic [ADDR_W-1:0] REG_SATURATION = 2'd3;

	localparam logic [2:0] SECTOR_0 = 3'd0;
	localparam logic [2:0] SECTOR_1 = 3'd1;
	localparam logic [2:0] SECTOR_2 = 3'd2;
	localparam logic [2:0] SECTOR_3 = 3'd3;
	localparam logic [2:0] SECTOR_4 = 3'd4;
	localparam logic [2:0] SECTOR_5 = 3'd5;

	typedef struct packed {
		logic              effect;
		logic [HUE_W-1:0]  from_hue;
		logic [HUE_W-1:0]  to_hue;
		logic [STEP_W-1:0] step;
	} job_t;

	typedef struct packed {
		logic [HUE_W-1:0] first_hue;
		logic [HUE_W-1:0] second_hue;
		logic [PCT_W-1:0] brightness_pct;
		logic [PCT_W-1:0] saturation_pct;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_QUOT,
		BK_HUE,
		BK_LOW,
		BK_ADJP,
		BK_ADJ,
		BK_DONE
	} bk_state_t;

endpackage

// File: hdl/lhfg_front.sv
// Front end: accepts commands, steps the selected ramp and queues hue jobs.
module lhfg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic                      cmd,
	input  logic                      effect_select,
	input  logic [lhfg_pkg::HUE_W-1:0] first_hue,
	input  logic [lhfg_pkg::HUE_W-1:0] second_hue,
	input  logic                      q_full,
	output logic                      push,
	output lhfg_pkg::job_t            push_job
);
	import lhfg_pkg::*;

	logic [STEP_W-1:0] a_step_q;
	logic              a_rev_q;
	logic [STEP_W-1:0] b_step_q;
	logic [HUE_W-1:0]  b_from_q;
	logic [HUE_W-1:0]  b_to_q;
	logic              accept;
	logic [9:0]        next_to_sum;
	logic [9:0]        next_to;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && (cmd == CMD_TICK);

	always_comb begin
		push_job.effect = effect_select;
		if (effect_select == EFFECT_RAMP) begin
			push_job.from_hue = a_rev_q ? second_hue : first_hue;
			push_job.to_hue   = a_rev_q ? first_hue : second_hue;
			push_job.step     = a_step_q;
		end else begin
			push_job.from_hue = b_from_q;
			push_job.to_hue   = b_to_q;
			push_job.step     = b_step_q;
		end
	end

	assign next_to_sum = {1'b0, b_from_q} + HUE_SECTOR;
	assign next_to     = (next_to_sum >= HUE_CIRCLE) ? next_to_sum - HUE_CIRCLE : next_to_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_step_q <= '0;
			a_rev_q  <= 1'b0;
			b_step_q <= '0;
			b_from_q <= '0;
			b_to_q   <= RAMP_B_TO_INIT;
		end else if (accept) begin
			if (cmd == CMD_CLEAR) begin
				a_step_q <= '0;
				a_rev_q  <= 1'b0;
				b_step_q <= '0;
				b_from_q <= '0;
				b_to_q   <= RAMP_B_TO_INIT;
			end else if (effect_select == EFFECT_RAMP) begin
				if (a_step_q == STEP_LAST) begin
					a_step_q <= '0;
					a_rev_q  <= !a_rev_q;
				end else begin
					a_step_q <= a_step_q + 1'b1;
				end
			end else begin
				if (b_step_q == STEP_LAST) begin
					b_step_q <= '0;
					b_from_q <= b_to_q;
					b_to_q   <= next_to[HUE_W-1:0];
				end else begin
					b_step_q <= b_step_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/lhfg_queue.sv
// Small register FIFO of hue jobs between front and back end.
module lhfg_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lhfg_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output lhfg_pkg::job_t head_job
);
	import lhfg_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/lhfg_back.sv
// Back end: hue interpolation, HSV to RGB conversion and output register.
module lhfg_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	input  lhfg_pkg::job_t             job,
	output logic                       pop,
	input  logic [lhfg_pkg::PCT_W-1:0] brightness_pct,
	input  logic [lhfg_pkg::PCT_W-1:0] saturation_pct,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [23:0]                m_tdata
);
	import lhfg_pkg::*;

	bk_state_t state_q, state_d;

	logic               effect_q;
	logic [HUE_W-1:0]   from_q;
	logic signed [17:0] prod_q;
	logic [14:0]        bprod_q;
	logic               neg_q;
	logic [9:0]         quot_q;
	logic [7:0]         peak_q;
	logic [2:0]         sector_q;
	logic [5:0]         diff_q;
	logic [14:0]        lprod_q;
	logic [7:0]         low_q;
	logic [13:0]        aprod_q;
	logic [7:0]         adj_q;
	logic               out_valid_q;
	logic [23:0]        out_data_q;

	logic signed [9:0]  span;
	logic signed [17:0] prod;
	logic [17:0]        mag_full;
	logic [32:0]        qprod;
	logic [31:0]        pkprod;
	logic [8:0]         peak_raw;
	logic signed [10:0] q_signed;
	logic signed [10:0] hue_sum;
	logic [9:0]         hue_pos;
	logic [9:0]         hue_mod;
	logic [2:0]         sector;
	logic [9:0]         sec_base;
	logic [PCT_W-1:0]   sat_clamped;
	logic [31:0]        lowprod;
	logic [28:0]        adjprod;
	logic [7:0]         red, green, blue;
	logic               load_out;

	// span * step
	assign span = $signed({1'b0, job.to_hue}) - $signed({1'b0, job.from_hue});
	assign prod = 18'(span * $signed({1'b0, job.step}));

	// truncating quotient by 100 on the magnitude, and peak level
	assign mag_full = prod_q[17] ? 18'(-prod_q) : 18'(prod_q);
	assign qprod    = 33'(mag_full[15:0]) * 33'(RECIP_100);
	assign pkprod   = 32'(bprod_q) * 32'(RECIP_100);
	assign peak_raw = pkprod[RECIP_100_SH+8:RECIP_100_SH];

	// hue, sector and offset inside the sector
	assign q_signed = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
	assign hue_sum  = $signed({2'b00, from_q}) + q_signed;
	assign hue_pos  = hue_sum[10] ? '0 : hue_sum[9:0];
	assign hue_mod  = (hue_pos >= HUE_CIRCLE) ? hue_pos - HUE_CIRCLE : hue_pos;

	always_comb begin
		if (hue_mod >= 10'd300) begin
			sector = SECTOR_5; sec_base = 10'd300;
		end else if (hue_mod >= 10'd240) begin
			sector = SECTOR_4; sec_base = 10'd240;
		end else if (hue_mod >= 10'd180) begin
			sector = SECTOR_3; sec_base = 10'd180;
		end else if (hue_mod >= 10'd120) begin
			sector = SECTOR_2; sec_base = 10'd120;
		end else if (hue_mod >= HUE_SECTOR) begin
			sector = SECTOR_1; sec_base = HUE_SECTOR;
		end else begin
			sector = SECTOR_0; sec_base = '0;
		end
	end

	assign sat_clamped = (saturation_pct > PCT_FULL) ? PCT_FULL : saturation_pct;
	assign lowprod     = 32'(lprod_q) * 32'(RECIP_100);
	assign adjprod     = 29'(aprod_q) * 29'(RECIP_60);

	always_comb begin
		case (sector_q)
			SECTOR_0: begin red = peak_q;         green = low_q + adj_q;  blue = low_q; end
			SECTOR_1: begin red = peak_q - adj_q; green = peak_q;         blue = low_q; end
			SECTOR_2: begin red = low_q;          green = peak_q;         blue = low_q + adj_q; end
			SECTOR_3: begin red = low_q;          green = peak_q - adj_q; blue = peak_q; end
			SECTOR_4: begin red = low_q + adj_q;  green = low_q;          blue = peak_q; end
			default:  begin red = peak_q;         green = low_q;          blue = peak_q - adj_q; end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					pop     = 1'b1;
					state_d = BK_QUOT;
				end
			end
			BK_QUOT: state_d = BK_HUE;
			BK_HUE:  state_d = BK_LOW;
			BK_LOW:  state_d = BK_ADJP;
			BK_ADJP: state_d = BK_ADJ;
			BK_ADJ:  state_d = BK_DONE;
			BK_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				effect_q <= job.effect;
				from_q   <= job.from_hue;
				prod_q   <= prod;
				bprod_q  <= 15'(brightness_pct) * 15'(LEVEL_MAX);
			end
			BK_QUOT: begin
				neg_q  <= prod_q[17];
				quot_q <= qprod[RECIP_100_SH+9:RECIP_100_SH];
				peak_q <= (peak_raw > 9'(LEVEL_MAX)) ? LEVEL_MAX : peak_raw[7:0];
			end
			BK_HUE: begin
				sector_q <= sector;
				diff_q   <= 6'(hue_mod - sec_base);
				lprod_q  <= 15'(peak_q) * 15'(PCT_FULL - sat_clamped);
			end
			BK_LOW:  low_q   <= lowprod[RECIP_100_SH+7:RECIP_100_SH];
			BK_ADJP: aprod_q <= 14'(peak_q - low_q) * 14'(diff_q);
			BK_ADJ:  adj_q   <= adjprod[RECIP_60_SH+7:RECIP_60_SH];
			BK_DONE: begin
				if (load_out) begin
					if (effect_q == EFFECT_RAMP) begin
						out_data_q <= {blue, green, red};
					end else begin
						out_data_q <= {red, blue, green};
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: hdl/led_hue_fade_generator_core.sv
// Top level of the LED hue fade generator: config registers, front, queue, back.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser: cmd; s_tdata[0]: effect_select
//  m_*     | out | m_tvalid/m_tready  | m_tdata: wire_byte0, wire_byte1, wire_byte2
//  cfg_*   | in  | cfg_we             | cfg_addr: register index; cfg_wdata: value
//
// A frame tick goes through the job queue and the back end's multiply sequencer,
// which takes one job at a time, before its result is registered. Clear commands
// give no result. The front keeps accepting while the job queue has room, also
// while a result waits on m_tready.
// Reset clears both ramps and loads the register defaults.
module led_hue_fade_generator_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [0] effect_select, [7:1] zero
	input  logic                        s_tuser,   // [0] cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // [7:0] byte0, [15:8] byte1, [23:16] byte2
	input  logic                        cfg_we,
	input  logic [lhfg_pkg::ADDR_W-1:0] cfg_addr,
	input  logic [lhfg_pkg::HUE_W-1:0]  cfg_wdata
);
	import lhfg_pkg::*;

	cfg_t cfg_q;
	logic push, pop, q_full, q_not_empty;
	job_t push_job, head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_hue      <= 9'd200;
			cfg_q.second_hue     <= 9'd320;
			cfg_q.brightness_pct <= PCT_FULL;
			cfg_q.saturation_pct <= PCT_FULL;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FIRST_HUE:  cfg_q.first_hue      <= cfg_wdata;
				REG_SECOND_HUE: cfg_q.second_hue     <= cfg_wdata;
				REG_BRIGHTNESS: cfg_q.brightness_pct <= cfg_wdata[PCT_W-1:0];
				REG_SATURATION: cfg_q.saturation_pct <= cfg_wdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	lhfg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.cmd          (s_tuser),
		.effect_select(s_tdata[0]),
		.first_hue    (cfg_q.first_hue),
		.second_hue   (cfg_q.second_hue),
		.q_full       (q_full),
		.push         (push),
		.push_job     (push_job)
	);

	lhfg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.head_job (head_job)
	);

	lhfg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (q_not_empty),
		.job           (head_job),
		.pop           (pop),
		.brightness_pct(cfg_q.brightness_pct),
		.saturation_pct(cfg_q.saturation_pct),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule
